// ===== src/assert_macros.svh =====
// Assertion macros shared by the weighted mean distance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/wmad_pkg.sv =====
// Shared types and constants of the weighted mean distance block.
`timescale 1ns / 1ps

package wmad_pkg;

    localparam int IN_W      = 96;
    localparam int OUT_W     = 32;
    localparam int CNT_W     = 9;
    localparam int WGT_W     = 24;
    localparam int VAL_W     = 32;
    localparam int WSUM_W    = 32;
    localparam int DSUM_W    = 49;
    localparam int PROD_W    = 40;
    localparam int Q_DEPTH   = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    localparam logic [CNT_W-1:0]        COUNT_MAX     = 9'd511;
    localparam logic [WGT_W-1:0]        WEIGHT_ONE    = 24'd65536;
    localparam logic signed [VAL_W-1:0] MISSING_LIMIT = -32'sd655294464;

    // Item kinds carried on tuser of the slave side
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PAIR = 1'b1;

    // End-of-vector job handed from the front end to the divider
    typedef struct packed {
        logic [DSUM_W-1:0] num;
        logic [WSUM_W-1:0] den;
        logic [CNT_W-1:0]  count;
        logic              no_data;
    } fin_t;

endpackage

// ===== src/wmad_front.sv =====
// Front end: item intake, weight table, weighting multiply and accumulation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wmad_front #(
    parameter int MAX_EXPERIMENTS = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [wmad_pkg::IN_W-1:0]   s_tdata,
    input  logic                        s_tuser,
    input  logic                        s_tlast,
    input  logic [wmad_pkg::QCNT_W-1:0] q_count,
    output logic                        push,
    output wmad_pkg::fin_t              push_data
);
    import wmad_pkg::*;

    localparam int IDX_W = (MAX_EXPERIMENTS > 1) ? $clog2(MAX_EXPERIMENTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_EXPERIMENTS - 1);

    logic [WGT_W-1:0] table_mem [MAX_EXPERIMENTS];
    logic [WGT_W-1:0] rd_data_reg;

    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next, cnt_inc;

    logic              s1_valid_reg, s1_last_reg, s1_miss_reg;
    logic [VAL_W-1:0]  s1_d_reg;
    logic [CNT_W-1:0]  s1_count_reg;

    logic              s2_valid_reg, s2_last_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [WGT_W-1:0]  s2_w_reg;
    logic [CNT_W-1:0]  s2_count_reg;

    logic [WSUM_W-1:0] wsum_reg, wsum_next, wsum_new;
    logic [DSUM_W-1:0] dsum_reg, dsum_next, dsum_new;

    logic                     accept, is_pair, load_ok, we;
    logic [IDX_W-1:0]         waddr, tix;
    logic [WGT_W-1:0]         wdata, w_eff;
    logic signed [VAL_W-1:0]  a_val, b_val;
    logic signed [VAL_W:0]    diff;
    logic [VAL_W-1:0]         abs_d;
    logic                     missing;
    logic [55:0]              prod_full;
    logic [1:0]               inflight;
    logic [QCNT_W:0]          slots_used;
    logic [WSUM_W:0]          wsum_add;
    logic [DSUM_W:0]          dsum_add;

    always_comb
    begin
        a_val   = s_tdata[63:32];
        b_val   = s_tdata[95:64];
        is_pair = (s_tuser == ACT_PAIR);

        // Reserve a queue slot for every end-of-vector item still in the pipe
        inflight   = {1'b0, s1_valid_reg & s1_last_reg} + {1'b0, s2_valid_reg & s2_last_reg};
        slots_used = {1'b0, q_count} + (QCNT_W+1)'(inflight);
        s_tready   = !clr_active_reg && (slots_used < (QCNT_W+1)'(Q_DEPTH));
        accept     = s_tvalid && s_tready;

        missing = (a_val < MISSING_LIMIT) || (b_val < MISSING_LIMIT);
        diff    = {a_val[VAL_W-1], a_val} - {b_val[VAL_W-1], b_val};
        abs_d   = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];

        cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 9'd1;
        if (int'(cnt_reg) > MAX_EXPERIMENTS - 1)
            tix = IDX_LAST;
        else
            tix = IDX_W'(cnt_reg);

        cnt_next = cnt_reg;
        if (accept && is_pair)
            cnt_next = s_tlast ? '0 : cnt_inc;

        load_ok = (int'(s_tdata[7:0]) < MAX_EXPERIMENTS);
        we      = clr_active_reg || (accept && !is_pair && load_ok);
        waddr   = clr_active_reg ? clr_idx_reg : IDX_W'(s_tdata[7:0]);
        wdata   = clr_active_reg ? WEIGHT_ONE : s_tdata[31:8];

        // Missing pairs add nothing to either sum
        w_eff     = s1_miss_reg ? '0 : rd_data_reg;
        prod_full = 56'(s1_d_reg) * 56'(w_eff);

        wsum_add = {1'b0, wsum_reg} + (WSUM_W+1)'(s2_w_reg);
        dsum_add = {1'b0, dsum_reg} + (DSUM_W+1)'(s2_prod_reg);
        wsum_new = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
        dsum_new = dsum_add[DSUM_W] ? '1 : dsum_add[DSUM_W-1:0];

        push              = s2_valid_reg && s2_last_reg;
        push_data.num     = dsum_new;
        push_data.den     = wsum_new;
        push_data.count   = s2_count_reg;
        push_data.no_data = (wsum_new == '0);

        wsum_next = wsum_reg;
        dsum_next = dsum_reg;
        if (s2_valid_reg)
        begin
            wsum_next = s2_last_reg ? '0 : wsum_new;
            dsum_next = s2_last_reg ? '0 : dsum_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            table_mem[waddr] <= wdata;
        if (accept && is_pair)
            rd_data_reg <= table_mem[tix];
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_pair)
        begin
            s1_d_reg     <= abs_d;
            s1_miss_reg  <= missing;
            s1_last_reg  <= s_tlast;
            s1_count_reg <= cnt_inc;
        end
        if (s1_valid_reg)
        begin
            s2_prod_reg  <= prod_full[55:16];
            s2_w_reg     <= w_eff;
            s2_last_reg  <= s1_last_reg;
            s2_count_reg <= s1_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            wsum_reg       <= '0;
            dsum_reg       <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == IDX_LAST)
                    clr_active_reg <= 1'b0;
            end
            cnt_reg      <= cnt_next;
            s1_valid_reg <= accept && is_pair;
            s2_valid_reg <= s1_valid_reg;
            wsum_reg     <= wsum_next;
            dsum_reg     <= dsum_next;
        end
    end

    `ASSERT_IMP(a_push_room, clk, rst_n, push, q_count < QCNT_W'(Q_DEPTH), "push into full queue")
    `ASSERT_NXT(a_sums_clear, clk, rst_n, push, (wsum_reg == '0) && (dsum_reg == '0), "sums kept after end of vector")

endmodule

// ===== src/wmad_queue.sv =====
// Short queue of end-of-vector jobs between front end and divider.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wmad_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  wmad_pkg::fin_t              push_data,
    input  logic                        pop,
    output wmad_pkg::fin_t              head,
    output logic [wmad_pkg::QCNT_W-1:0] count
);
    import wmad_pkg::*;

    fin_t              entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        head       = entry_reg[rd_ptr_reg];
        count      = count_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `ASSERT_IMP(a_pop_nonempty, clk, rst_n, pop, count_reg != '0, "pop from empty queue")
    `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(Q_DEPTH), "queue overfilled")

endmodule

// ===== src/wmad_back.sv =====
// Back end: radix-2 quotient unit and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wmad_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wmad_pkg::fin_t               head,
    input  logic [wmad_pkg::QCNT_W-1:0]  q_count,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wmad_pkg::OUT_W-1:0]   m_tdata,
    output logic                         m_tuser
);
    import wmad_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [31:0]      den_reg, den_next;
    logic [4:0]       step_reg, step_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    logic             out_nd_reg, out_nd_next;

    logic [32:0] trial;
    logic        ge;
    logic        ovf;

    always_comb
    begin
        trial = {rem_reg, quo_reg[31]};
        ge    = (trial >= {1'b0, den_reg});
        // Quotient of 2^16 or more saturates
        ovf   = (head.num >= {1'b0, head.den, 16'b0});

        state_next    = state_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        step_next     = step_reg;
        out_data_next = out_data_reg;
        out_nd_next   = out_nd_reg;
        pop           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_count != '0)
                begin
                    pop         = 1'b1;
                    out_nd_next = head.no_data;
                    if (head.no_data)
                    begin
                        out_data_next = {7'b0, head.count, 16'b0};
                        state_next    = ST_OUT;
                    end
                    else if (ovf)
                    begin
                        out_data_next = '1;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        rem_next   = head.num[47:16];
                        quo_next   = {head.num[15:0], 16'b0};
                        den_next   = head.den;
                        step_next  = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                quo_next  = {quo_reg[30:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd31)
                begin
                    out_data_next = {quo_reg[30:0], ge};
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_nd_reg;

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        step_reg     <= step_next;
        out_data_reg <= out_data_next;
        out_nd_reg   <= out_nd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `ASSERT_IMP(a_pop_idle, clk, rst_n, pop, state_reg == ST_IDLE, "pop while busy")
    `ASSERT_IMP(a_nodata_whole, clk, rst_n, m_tvalid && m_tuser, m_tdata[15:0] == '0, "count result has fraction")

endmodule

// ===== src/weighted_mean_abs_distance.sv =====
// Top level of the weighted mean absolute distance block.
// Slave stream: one item per transfer. tuser = 1 carries an element pair
// (a_value, b_value), tuser = 0 loads weight_value into table entry
// weight_index. tlast on a pair closes the vector and causes one result.
// Master stream: tdata is the weighted mean |a-b| in Q16.16, or the element
// count in Q16.16 with tuser (no_data) high when the weight sum was zero.
// Items are taken one per cycle while s_tready is high; the front end is a
// three-stage pipe (table read, 32x24 multiply, saturating accumulate).
// m_tvalid rises once the closing pair has passed the front pipe, the queue
// and the quotient unit, which produces one bit per cycle; a no-data or
// saturated result skips the quotient unit. Up to four closed vectors wait
// in a queue; s_tready drops when they and the closing pairs still in the pipe fill it.
// After reset the weight table is swept to 1.0, one entry per cycle, so
// s_tready stays low until every entry is written. A stalled receiver holds
// the result; the input keeps flowing until the queue fills.
`timescale 1ns / 1ps

module weighted_mean_abs_distance #(
    parameter int MAX_EXPERIMENTS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // weight_index[7:0], weight_value[31:8], a_value[63:32], b_value[95:64]
    input  logic [wmad_pkg::IN_W-1:0]  s_tdata,
    // action
    input  logic                       s_tuser,
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // mean_distance[31:0]
    output logic [wmad_pkg::OUT_W-1:0] m_tdata,
    // no_data
    output logic                       m_tuser
);
    import wmad_pkg::*;

    logic              push, pop;
    fin_t              push_data, head;
    logic [QCNT_W-1:0] q_count;

    wmad_front #(
        .MAX_EXPERIMENTS(MAX_EXPERIMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    wmad_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .count     (q_count)
    );

    wmad_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_count  (q_count),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
